>>> hw/rtl/hmap_pkg.sv
// hmap_pkg: shared types and constants of the chained hash map.
// Item structs, operation codes, controller states, and the controller-to-datapath
// command and status structs. Has no dependencies.
package hmap_pkg;

	localparam int NUM_ENTRIES_DEF     = 1024;
	localparam int MAX_BUCKET_BITS_DEF = 11;
	localparam int MIN_BUCKET_BITS     = 7;
	localparam int BUCKET_BITS_RST     = 11;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] tag_part_a;
		logic [63:0] tag_part_b;
		logic [31:0] tag_part_c;
		logic [31:0] hash_value;
		logic [9:0]  slot_index;
	} req_t;

	typedef struct packed {
		logic       found;
		logic [9:0] match_index;
		logic       status;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_HEAD,
		ST_CHK_HEAD,
		ST_CMP,
		ST_INS
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic load_req;
		logic head_rd;
		logic walk_start;
		logic walk_next;
		logic del_unlink;
		logic ins_write;
		logic finish;
		logic hit;
	} cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic [1:0] op;
		logic       head_empty;
		logic       hit;
		logic       chain_end;
		logic       slot_ok;
	} sts_t;

endpackage

>>> hw/rtl/hmap_ctrl.sv
// hmap_ctrl: controller state machine of the hash map.
// Sequences the head clear, head read, chain walk and updates. Uses hmap_pkg.
module hmap_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  hmap_pkg::sts_t sts,
	output hmap_pkg::cmd_t cmd,
	output logic           busy
);
	import hmap_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load_req = 1'b1;
					state_d      = ST_RD_HEAD;
				end
			end
			ST_RD_HEAD: begin
				if (sts.op != OP_LOOKUP && sts.op != OP_INSERT && sts.op != OP_DELETE) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.head_rd = 1'b1;
					state_d     = ST_CHK_HEAD;
				end
			end
			ST_CHK_HEAD: begin
				cmd.walk_start = 1'b1;
				if (!sts.head_empty) begin
					state_d = ST_CMP;
				end else if (sts.op == OP_INSERT && sts.slot_ok) begin
					state_d = ST_INS;
				end else begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_CMP: begin
				if (sts.hit) begin
					cmd.del_unlink = (sts.op == OP_DELETE);
					cmd.finish     = 1'b1;
					cmd.hit        = 1'b1;
					state_d        = ST_IDLE;
				end else if (!sts.chain_end) begin
					cmd.walk_next = 1'b1;
				end else if (sts.op == OP_INSERT && sts.slot_ok) begin
					state_d = ST_INS;
				end else begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_INS: begin
				cmd.ins_write = 1'b1;
				cmd.finish    = 1'b1;
				state_d       = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/hmap_dp.sv
// hmap_dp: datapath of the hash map: head, entry and link memories, walk registers,
// config register and result register. Uses hmap_pkg; driven by hmap_ctrl.
module hmap_dp #(
	parameter int NUM_ENTRIES     = hmap_pkg::NUM_ENTRIES_DEF,
	parameter int MAX_BUCKET_BITS = hmap_pkg::MAX_BUCKET_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  hmap_pkg::req_t req,
	input  hmap_pkg::cmd_t cmd,
	input  logic           cfg_we,
	input  logic [3:0]     cfg_wdata,
	output hmap_pkg::sts_t sts,
	output logic           done,
	output hmap_pkg::rsp_t rsp
);
	import hmap_pkg::*;

	localparam int IDX_W    = $clog2(NUM_ENTRIES);
	localparam int LINK_W   = IDX_W + 1;
	localparam int HEAD_CNT = 1 << MAX_BUCKET_BITS;
	localparam int BB_W     = $clog2(MAX_BUCKET_BITS + 1);
	localparam int BB_RST   = (BUCKET_BITS_RST > MAX_BUCKET_BITS) ? MAX_BUCKET_BITS :
	                          BUCKET_BITS_RST;
	localparam int ENT_W    = 192;
	localparam logic [LINK_W-1:0] EMPTY = LINK_W'(NUM_ENTRIES);

	logic [LINK_W-1:0] head_mem [HEAD_CNT];
	logic [ENT_W-1:0]  entry_mem [NUM_ENTRIES];
	logic [LINK_W-1:0] link_mem [NUM_ENTRIES];

	logic [BB_W-1:0]            bb_q;
	req_t                       req_q;
	logic [MAX_BUCKET_BITS-1:0] bucket_q, bucket_d;
	logic [MAX_BUCKET_BITS-1:0] clr_cnt_q;
	logic [LINK_W-1:0]          head_rd_q, head_q, cur_q, prev_q, link_rd_q;
	logic [ENT_W-1:0]           ent_rd_q;
	logic [IDX_W-1:0]           steps_q;
	logic                       done_q;
	rsp_t                       rsp_q;

	logic [31:0]                cfg_v, cfg_c;
	logic                       head_we, link_we;
	logic [MAX_BUCKET_BITS-1:0] head_wa;
	logic [LINK_W-1:0]          head_wd, link_wd, rd_addr;
	logic [IDX_W-1:0]           link_wa, slot_idx;
	logic                       prev_empty, tag_eq, hash_eq;

	// config register, clamped on write
	always_comb begin
		cfg_v = 32'(cfg_wdata);
		if (cfg_v < 32'(MIN_BUCKET_BITS)) begin
			cfg_c = 32'(MIN_BUCKET_BITS);
		end else if (cfg_v > 32'(MAX_BUCKET_BITS)) begin
			cfg_c = 32'(MAX_BUCKET_BITS);
		end else begin
			cfg_c = cfg_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bb_q      <= BB_W'(BB_RST);
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				bb_q <= cfg_c[BB_W-1:0];
			end
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			done_q <= cmd.finish;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_BUCKET_BITS; i++) begin
			bucket_d[i] = req.hash_value[i] & (32'(i) < 32'(bb_q));
		end
	end

	assign slot_idx   = IDX_W'(req_q.slot_index);
	assign prev_empty = (32'(prev_q) >= 32'(NUM_ENTRIES));
	assign rd_addr    = cmd.walk_start ? head_rd_q : link_rd_q;

	// request, walk and result registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q    <= req;
			bucket_q <= bucket_d;
		end
		if (cmd.head_rd) begin
			head_rd_q <= head_mem[bucket_q];
		end
		if (cmd.walk_start) begin
			head_q  <= head_rd_q;
			cur_q   <= head_rd_q;
			prev_q  <= EMPTY;
			steps_q <= '0;
		end else if (cmd.walk_next) begin
			prev_q  <= cur_q;
			cur_q   <= link_rd_q;
			steps_q <= steps_q + 1'b1;
		end
		if (cmd.walk_start || cmd.walk_next) begin
			ent_rd_q  <= entry_mem[rd_addr[IDX_W-1:0]];
			link_rd_q <= link_mem[rd_addr[IDX_W-1:0]];
		end
		if (cmd.finish) begin
			rsp_q.found       <= cmd.hit;
			rsp_q.match_index <= cmd.hit ? 10'(cur_q) : 10'd0;
			rsp_q.status      <= !cmd.hit && (req_q.operation == OP_DELETE);
		end
	end

	// write port selection
	always_comb begin
		head_we = 1'b0;
		head_wa = bucket_q;
		head_wd = link_rd_q;
		priority if (cmd.clr_step) begin
			head_we = 1'b1;
			head_wa = clr_cnt_q;
			head_wd = EMPTY;
		end else if (cmd.ins_write) begin
			head_we = 1'b1;
			head_wd = LINK_W'(slot_idx);
		end else if (cmd.del_unlink && prev_empty) begin
			head_we = 1'b1;
		end
	end

	always_comb begin
		link_we = 1'b0;
		link_wa = prev_q[IDX_W-1:0];
		link_wd = link_rd_q;
		priority if (cmd.ins_write) begin
			link_we = 1'b1;
			link_wa = slot_idx;
			link_wd = head_q;
		end else if (cmd.del_unlink && !prev_empty) begin
			link_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_wa] <= head_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_write) begin
			entry_mem[slot_idx] <= {req_q.tag_part_a, req_q.tag_part_b, req_q.tag_part_c,
			                        req_q.hash_value};
		end
	end

	assign tag_eq  = (ent_rd_q[ENT_W-1:32] ==
	                  {req_q.tag_part_a, req_q.tag_part_b, req_q.tag_part_c});
	assign hash_eq = (ent_rd_q[31:0] == req_q.hash_value);

	always_comb begin
		sts.clr_last   = &clr_cnt_q;
		sts.op         = req_q.operation;
		sts.head_empty = (32'(head_rd_q) >= 32'(NUM_ENTRIES));
		sts.hit        = tag_eq && (hash_eq || req_q.operation != OP_DELETE);
		sts.chain_end  = (32'(link_rd_q) >= 32'(NUM_ENTRIES)) ||
		                 (steps_q == IDX_W'(NUM_ENTRIES - 1));
		sts.slot_ok    = (32'(req_q.slot_index) < 32'(NUM_ENTRIES));
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_unlink_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.del_unlink |-> sts.hit && req_q.operation == OP_DELETE)
		else $error("unlink without a matching entry");
	a_insert_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_write |-> sts.slot_ok && req_q.operation == OP_INSERT)
		else $error("insert write with bad slot or op");
	a_walk_continues: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_next |-> !sts.hit && !sts.chain_end)
		else $error("walk advanced past a hit or chain end");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

endmodule

>>> hw/rtl/chained_hash_map_fixed_slots_top.sv
// chained_hash_map_fixed_slots_top: top level of the chained hash map.
// Joins hmap_ctrl and hmap_dp; uses hmap_pkg.
//
//   channel   signals                 handshake
//   request   start, busy, req        taken when start && !busy
//   result    done, rsp               valid for the one cycle done is high
//   config    cfg_we, cfg_wdata       written when cfg_we is high
//
// An item passes from acceptance through a head read and then one entry memory read per
// chain entry compared, plus a write state (ST_INS) for an insert that writes.
// An unused operation code ends in ST_RD_HEAD without a head read.
// After reset the head memory is cleared, one head a cycle, all 2**MAX_BUCKET_BITS heads
// (2048 at default) with busy high; config writes are taken throughout.
// Results cannot be held off; busy stays high while an item is in work.
module chained_hash_map_fixed_slots_top #(
	parameter int NUM_ENTRIES     = hmap_pkg::NUM_ENTRIES_DEF,
	parameter int MAX_BUCKET_BITS = hmap_pkg::MAX_BUCKET_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  hmap_pkg::req_t req,
	output logic           done,
	output hmap_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic [3:0]     cfg_wdata
);
	import hmap_pkg::*;

	cmd_t cmd;
	sts_t sts;

	hmap_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	hmap_dp #(
		.NUM_ENTRIES     (NUM_ENTRIES),
		.MAX_BUCKET_BITS (MAX_BUCKET_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sts       (sts),
		.done      (done),
		.rsp       (rsp)
	);

endmodule

>>> verif/tb.sv
// tb: self-checking testbench for chained_hash_map_fixed_slots_top.
// Drives lookup/insert/delete items from a queue, predicts every result with a
// behavioral hash map and checks it on the done strobe. Uses hmap_pkg.
`timescale 1ns / 100ps

module tb;
	import hmap_pkg::*;

	localparam int ENTRY_COUNT   = NUM_ENTRIES_DEF;
	localparam int HEAD_COUNT    = 1 << MAX_BUCKET_BITS_DEF;
	localparam logic [10:0] EMPTY_LINK = 11'(NUM_ENTRIES_DEF);
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int EXP_DEPTH     = 4096;
	localparam int OPS_PER_PHASE = 200;
	localparam int TAIL_ITEMS    = 150;
	localparam int TAIL_CYCLES   = 64;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int LOOP_SLOT     = 1022;

	typedef enum logic [1:0] {STEP_ITEM, STEP_CFG, STEP_DRAIN} step_kind_t;

	typedef struct {
		step_kind_t  kind;
		req_t        item;
		logic [3:0]  cfg_value;
	} step_t;

	typedef struct {
		logic [159:0] tag;
		logic [31:0]  hash;
		logic [9:0]   slot;
	} key_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	req_t       req = '0;
	logic       done;
	rsp_t       rsp;
	logic       cfg_we = 1'b0;
	logic [3:0] cfg_wdata = '0;

	step_t op_queue[$];
	rsp_t  expected_rsp [EXP_DEPTH];
	int    exp_wr = 0;
	int    exp_rd = 0;
	int    fail_count = 0;
	int    cycle_count = 0;
	int    gap_left = 0;
	int    n_accepted = 0;

	// shadow hash map
	logic [10:0]  bucket_head [HEAD_COUNT];
	logic [159:0] ent_tag [ENTRY_COUNT];
	logic [31:0]  ent_hash [ENTRY_COUNT];
	logic [10:0]  ent_link [ENTRY_COUNT];
	int           bucket_bits;

	logic       drv_start;
	logic       drv_cfg_we;
	req_t       drv_req;
	logic [3:0] drv_wdata;
	rsp_t       drv_rsp;
	rsp_t       mon_want;

	chained_hash_map_fixed_slots_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	function automatic rsp_t hmap_predict(req_t r);
		rsp_t         res;
		logic [10:0]  id;
		logic [10:0]  prev;
		logic [159:0] tag;
		int           steps;
		int unsigned  bkt;
		res = '0;
		tag = {r.tag_part_a, r.tag_part_b, r.tag_part_c};
		bkt = r.hash_value & ((32'd1 << bucket_bits) - 32'd1);
		id = bucket_head[bkt];
		prev = EMPTY_LINK;
		steps = 0;
		case (r.operation)
			OP_LOOKUP, OP_INSERT: begin
				while (id < EMPTY_LINK && steps < ENTRY_COUNT && !res.found) begin
					if (ent_tag[id[9:0]] == tag) begin
						res.found = 1'b1;
						res.match_index = id[9:0];
					end else begin
						id = ent_link[id[9:0]];
						steps++;
					end
				end
				if (!res.found && r.operation == OP_INSERT) begin
					ent_tag[r.slot_index] = tag;
					ent_hash[r.slot_index] = r.hash_value;
					ent_link[r.slot_index] = bucket_head[bkt];
					bucket_head[bkt] = {1'b0, r.slot_index};
				end
			end
			OP_DELETE: begin
				while (id < EMPTY_LINK && steps < ENTRY_COUNT && !res.found) begin
					if (ent_hash[id[9:0]] == r.hash_value && ent_tag[id[9:0]] == tag) begin
						if (prev < EMPTY_LINK)
							ent_link[prev[9:0]] = ent_link[id[9:0]];
						else
							bucket_head[bkt] = ent_link[id[9:0]];
						res.found = 1'b1;
						res.match_index = id[9:0];
					end else begin
						prev = id;
						id = ent_link[id[9:0]];
						steps++;
					end
				end
				res.status = !res.found;
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic key_t make_key(logic [159:0] tag, logic [31:0] hash);
		key_t k;
		k.tag = tag;
		k.hash = hash;
		k.slot = '0;
		return k;
	endfunction

	function automatic key_t fresh_key();
		key_t k;
		k = make_key({$urandom, $urandom, $urandom, $urandom, $urandom}, $urandom);
		// crowd half the keys into a few buckets to build chains
		if ($urandom_range(0, 1))
			k.hash[10:0] = 11'($urandom_range(0, 31));
		return k;
	endfunction

	function automatic void push_op(logic [1:0] op, key_t k, logic [9:0] slot);
		step_t s;
		s.kind = STEP_ITEM;
		s.item.operation = op;
		{s.item.tag_part_a, s.item.tag_part_b, s.item.tag_part_c} = k.tag;
		s.item.hash_value = k.hash;
		s.item.slot_index = slot;
		s.cfg_value = '0;
		op_queue.push_back(s);
	endfunction

	function automatic void push_ctl(step_kind_t kind, logic [3:0] value);
		step_t s;
		s.kind = kind;
		s.item = '0;
		s.cfg_value = value;
		op_queue.push_back(s);
	endfunction

	initial begin
		forever #10 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			cfg_we <= 1'b0;
			cfg_wdata <= '0;
			exp_wr <= 0;
			gap_left = 0;
			bucket_bits = BUCKET_BITS_RST;
			for (int i = 0; i < HEAD_COUNT; i++)
				bucket_head[i] = EMPTY_LINK;
		end else begin
			drv_start = start;
			drv_req = req;
			drv_cfg_we = 1'b0;
			drv_wdata = cfg_wdata;
			if (cfg_we) begin
				if (int'(cfg_wdata) < MIN_BUCKET_BITS)
					bucket_bits = MIN_BUCKET_BITS;
				else if (int'(cfg_wdata) > MAX_BUCKET_BITS_DEF)
					bucket_bits = MAX_BUCKET_BITS_DEF;
				else
					bucket_bits = int'(cfg_wdata);
			end
			if (start && !busy) begin
				drv_rsp = hmap_predict(req);
				expected_rsp[exp_wr % EXP_DEPTH] <= drv_rsp;
				exp_wr <= exp_wr + 1;
				n_accepted++;
				drv_start = 1'b0;
				if (op_queue.size() > TAIL_ITEMS && (n_accepted / 64) % 3 != 2 &&
						$urandom_range(0, 3) == 0)
					gap_left = $urandom_range(1, 3);
			end
			if (!drv_start) begin
				if (gap_left > 0) begin
					// idle cycles count only while the block could take an item
					if (!busy && !start)
						gap_left--;
				end else if (op_queue.size() > 0) begin
					case (op_queue[0].kind)
						STEP_ITEM: begin
							drv_start = 1'b1;
							drv_req = op_queue[0].item;
							void'(op_queue.pop_front());
						end
						default: begin
							if (!start && !done && exp_wr == exp_rd) begin
								if (op_queue[0].kind == STEP_CFG) begin
									drv_cfg_we = 1'b1;
									drv_wdata = op_queue[0].cfg_value;
								end
								void'(op_queue.pop_front());
							end
						end
					endcase
				end
			end
			start <= drv_start;
			req <= drv_req;
			cfg_we <= drv_cfg_we;
			cfg_wdata <= drv_wdata;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_rd <= 0;
		end else if (done) begin
			if (exp_rd == exp_wr) begin
				$error("result with no item pending: found %0d match_index %0d status %0d",
					rsp.found, rsp.match_index, rsp.status);
				fail_count++;
			end else begin
				mon_want = expected_rsp[exp_rd % EXP_DEPTH];
				if (rsp.found !== mon_want.found) begin
					$error("found: expected %0d, actual %0d", mon_want.found, rsp.found);
					fail_count++;
				end
				if (rsp.match_index !== mon_want.match_index) begin
					$error("match_index: expected %0d, actual %0d",
						mon_want.match_index, rsp.match_index);
					fail_count++;
				end
				if (rsp.status !== mon_want.status) begin
					$error("status: expected %0d, actual %0d", mon_want.status, rsp.status);
					fail_count++;
				end
				exp_rd <= exp_rd + 1;
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		key_t       ka, kb, kc, kd, ke, kf, kg, kh, k;
		key_t       live_keys[$];
		int         free_slots[$];
		int         pick;
		int         idx;
		logic [3:0] phase_bits[8];

		phase_bits = '{4'd7, 4'd11, 4'd15, 4'd9, 4'd0, 4'd8, 4'd10, 4'd12};
		for (int i = 0; i < ENTRY_COUNT; i++)
			if (i != LOOP_SLOT)
				free_slots.push_back(i);

		ka = make_key('0, 32'h0000_0000);
		kb = make_key('1, 32'hFFFF_FFFF);
		k = fresh_key();
		kc = make_key(k.tag, 32'h0000_0800);
		push_op(OP_LOOKUP, ka, 10'd0);
		push_op(OP_DELETE, ka, 10'd0);
		push_op(OP_INSERT, ka, 10'd0);
		push_op(OP_INSERT, kb, 10'd1023);
		push_op(OP_INSERT, kc, 10'd5);
		push_op(OP_LOOKUP, ka, 10'd1023);
		push_op(OP_INSERT, ka, 10'd7);
		k = ka;
		k.hash = 32'h8000_0000;
		// same bucket, other hash: lookup hits, delete misses
		push_op(OP_LOOKUP, k, 10'd0);
		push_op(OP_DELETE, k, 10'd0);
		push_op(OP_DELETE, ka, 10'd0);
		push_op(OP_LOOKUP, kc, 10'd0);
		push_op(OP_UNUSED, kb, 10'd1023);
		push_op(OP_DELETE, kc, 10'd0);
		push_op(OP_DELETE, kb, 10'd0);
		// narrowing the bucket mask leaves linked entries where they are
		k = fresh_key();
		kd = make_key(k.tag, 32'h0000_0100);
		push_op(OP_INSERT, kd, 10'd9);
		push_ctl(STEP_CFG, 4'd7);
		push_op(OP_LOOKUP, kd, 10'd0);
		push_ctl(STEP_CFG, 4'd11);
		push_op(OP_LOOKUP, kd, 10'd0);
		push_op(OP_DELETE, kd, 10'd0);
		// relinking a linked slot into its own bucket makes a loop; the walk
		// bound ends the search, then a relink elsewhere cuts the loop
		k = fresh_key();
		ke = make_key(k.tag, 32'h0000_0123);
		k = fresh_key();
		kf = make_key(k.tag, 32'h0000_0123);
		k = fresh_key();
		kg = make_key(k.tag, 32'h0000_0123);
		k = fresh_key();
		kh = make_key(k.tag, 32'h0000_0456);
		push_op(OP_INSERT, ke, 10'(LOOP_SLOT));
		push_op(OP_INSERT, kf, 10'(LOOP_SLOT));
		push_op(OP_LOOKUP, kg, 10'd0);
		push_op(OP_DELETE, kg, 10'd0);
		push_op(OP_LOOKUP, kf, 10'd0);
		push_op(OP_INSERT, kh, 10'(LOOP_SLOT));
		push_op(OP_DELETE, kh, 10'd0);

		for (int p = 0; p < 8; p++) begin
			push_ctl(STEP_CFG, phase_bits[p]);
			for (int n = 0; n < OPS_PER_PHASE; n++) begin
				if (p == 3 && n == OPS_PER_PHASE / 2)
					push_ctl(STEP_DRAIN, 4'd0);
				pick = $urandom_range(0, 99);
				if (live_keys.size() == 0 && pick >= 35 && pick < 95)
					pick = 0;
				if (pick < 45 && free_slots.size() == 0)
					pick = 50;
				if (pick < 35) begin
					k = fresh_key();
					idx = $urandom_range(0, free_slots.size() - 1);
					k.slot = 10'(free_slots[idx]);
					free_slots.delete(idx);
					live_keys.push_back(k);
					push_op(OP_INSERT, k, k.slot);
				end else if (pick < 45) begin
					k = live_keys[$urandom_range(0, live_keys.size() - 1)];
					push_op(OP_INSERT, k, 10'($urandom));
				end else if (pick < 65) begin
					k = live_keys[$urandom_range(0, live_keys.size() - 1)];
					if ($urandom_range(0, 3) == 0)
						k.hash[31] = ~k.hash[31];
					push_op(OP_LOOKUP, k, 10'($urandom));
				end else if (pick < 75) begin
					push_op(OP_LOOKUP, fresh_key(), 10'($urandom));
				end else if (pick < 90) begin
					idx = $urandom_range(0, live_keys.size() - 1);
					k = live_keys[idx];
					live_keys.delete(idx);
					free_slots.push_back(int'(k.slot));
					push_op(OP_DELETE, k, 10'($urandom));
				end else if (pick < 95) begin
					if ($urandom_range(0, 1)) begin
						k = live_keys[$urandom_range(0, live_keys.size() - 1)];
						k.hash[31] = ~k.hash[31];
					end else begin
						k = fresh_key();
					end
					push_op(OP_DELETE, k, 10'($urandom));
				end else begin
					push_op(OP_UNUSED, fresh_key(), 10'($urandom));
				end
			end
			// empty the table before the mask changes
			while (live_keys.size() > 0) begin
				k = live_keys.pop_front();
				free_slots.push_back(int'(k.slot));
				push_op(OP_DELETE, k, 10'($urandom));
			end
			push_ctl(STEP_DRAIN, 4'd0);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (op_queue.size() != 0 || start || exp_rd != exp_wr)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
